@@ design/wrp_pkg.sv @@
// Shared types and constants of the WAV header parser.
package wrp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BADRIFF  = 3'd1;
   localparam logic [2:0] ST_BADWAVE  = 3'd2;
   localparam logic [2:0] ST_TRUNC    = 3'd3;
   localparam logic [2:0] ST_NOFMT    = 3'd4;
   localparam logic [2:0] ST_SHORTFMT = 3'd5;

   localparam int RSP_BITS = 117;
   localparam int RSP_DATA_BITS = 120;

   typedef struct packed {
      logic [31:0] audio_length;
      logic [31:0] audio_start;
      logic [15:0] frame_bytes;
      logic [31:0] rate_hz;
      logic [1:0]  sample_format;
      logic [2:0]  status;
   } wrp_result_type;

endpackage

@@ design/wrp_parser.sv @@
// Parse state of the RIFF/WAVE walk and its one-byte update logic.
module wrp_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              data_byte,
   input  logic                    first_byte,
   input  logic                    last_byte,
   output logic                    emit,
   output wrp_pkg::wrp_result_type result
);
   import wrp_pkg::*;

   localparam logic [2:0] PH_RIFF  = 3'd0;
   localparam logic [2:0] PH_RSIZE = 3'd1;
   localparam logic [2:0] PH_WAVE  = 3'd2;
   localparam logic [2:0] PH_CTAG  = 3'd3;
   localparam logic [2:0] PH_CSIZE = 3'd4;
   localparam logic [2:0] PH_FMT   = 3'd5;
   localparam logic [2:0] PH_SKIP  = 3'd6;
   localparam logic [2:0] PH_DONE  = 3'd7;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  field_count_ff, field_count_in;
   logic [31:0] shift_word_ff, shift_word_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [32:0] skip_left_ff, skip_left_in;
   logic [31:0] byte_position_ff, byte_position_in;
   logic        have_format_ff, have_format_in;
   logic [15:0] channel_count_ff, channel_count_in;
   logic [15:0] sample_bits_ff, sample_bits_in;
   logic [31:0] rate_store_ff, rate_store_in;
   logic [15:0] align_store_ff, align_store_in;
   logic        finished_ff, finished_in;

   always_comb begin
      logic was_finished;
      if (first_byte) begin
         phase_in         = PH_RIFF;
         field_count_in   = '0;
         shift_word_in    = '0;
         chunk_tag_in     = '0;
         skip_left_in     = '0;
         byte_position_in = '0;
         have_format_in   = 1'b0;
         channel_count_in = 16'd2;
         sample_bits_in   = 16'd16;
         rate_store_in    = '0;
         align_store_in   = '0;
         finished_in      = 1'b0;
      end else begin
         phase_in         = phase_ff;
         field_count_in   = field_count_ff;
         shift_word_in    = shift_word_ff;
         chunk_tag_in     = chunk_tag_ff;
         skip_left_in     = skip_left_ff;
         byte_position_in = byte_position_ff;
         have_format_in   = have_format_ff;
         channel_count_in = channel_count_ff;
         sample_bits_in   = sample_bits_ff;
         rate_store_in    = rate_store_ff;
         align_store_in   = align_store_ff;
         finished_in      = finished_ff;
      end
      emit = 1'b0;
      result = '0;
      was_finished = finished_in;

      if (!was_finished) begin
         byte_position_in = byte_position_in + 32'd1;
         if (phase_in == PH_SKIP) begin
            if (skip_left_in != '0) begin
               skip_left_in = skip_left_in - 33'd1;
            end
            if (skip_left_in == '0) begin
               phase_in = PH_CTAG;
               field_count_in = '0;
            end
         end else begin
            shift_word_in = {data_byte, shift_word_in[31:8]};
            field_count_in = field_count_in + 5'd1;
            if (phase_in == PH_FMT) begin
               if (field_count_in == 5'd4) begin
                  channel_count_in = shift_word_in[31:16];
               end else if (field_count_in == 5'd8) begin
                  rate_store_in = shift_word_in;
               end else if (field_count_in == 5'd14) begin
                  align_store_in = shift_word_in[31:16];
               end else if (field_count_in == 5'd16) begin
                  sample_bits_in = shift_word_in[31:16];
                  have_format_in = 1'b1;
                  field_count_in = '0;
                  phase_in = (skip_left_in == '0) ? PH_CTAG : PH_SKIP;
               end
            end else if (field_count_in >= 5'd4) begin
               field_count_in = '0;
               unique case (phase_in)
                  PH_RIFF: begin
                     if (shift_word_in != TAG_RIFF) begin
                        emit = 1'b1;
                        result.status = ST_BADRIFF;
                     end else begin
                        phase_in = PH_RSIZE;
                     end
                  end
                  PH_RSIZE: begin
                     phase_in = PH_WAVE;
                  end
                  PH_WAVE: begin
                     if (shift_word_in != TAG_WAVE) begin
                        emit = 1'b1;
                        result.status = ST_BADWAVE;
                     end else begin
                        phase_in = PH_CTAG;
                     end
                  end
                  PH_CTAG: begin
                     chunk_tag_in = shift_word_in;
                     phase_in = PH_CSIZE;
                  end
                  default: begin
                     if (chunk_tag_in == TAG_DATA) begin
                        emit = 1'b1;
                        if (!have_format_in) begin
                           result.status = ST_NOFMT;
                        end else begin
                           result.status = ST_OK;
                           result.sample_format = {channel_count_in != 16'd1,
                                                   sample_bits_in != 16'd8};
                           result.rate_hz = rate_store_in;
                           result.frame_bytes = align_store_in;
                           result.audio_start = byte_position_in;
                           result.audio_length = shift_word_in;
                        end
                     end else if (chunk_tag_in == TAG_FMT) begin
                        if (shift_word_in < 32'd16) begin
                           emit = 1'b1;
                           result.status = ST_SHORTFMT;
                        end else begin
                           skip_left_in = {1'b0, shift_word_in - 32'd16}
                                          + {32'd0, shift_word_in[0]};
                           phase_in = PH_FMT;
                        end
                     end else begin
                        skip_left_in = {1'b0, shift_word_in}
                                       + {32'd0, shift_word_in[0]};
                        phase_in = (skip_left_in == '0) ? PH_CTAG : PH_SKIP;
                     end
                  end
               endcase
            end
         end
      end

      if (!emit && last_byte && !was_finished) begin
         emit = 1'b1;
         result = '0;
         result.status = ST_TRUNC;
      end
      if (emit) begin
         finished_in = 1'b1;
         phase_in = PH_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_RIFF;
         field_count_ff   <= '0;
         shift_word_ff    <= '0;
         chunk_tag_ff     <= '0;
         skip_left_ff     <= '0;
         byte_position_ff <= '0;
         have_format_ff   <= 1'b0;
         channel_count_ff <= 16'd2;
         sample_bits_ff   <= 16'd16;
         rate_store_ff    <= '0;
         align_store_ff   <= '0;
         finished_ff      <= 1'b0;
      end else if (step) begin
         phase_ff         <= phase_in;
         field_count_ff   <= field_count_in;
         shift_word_ff    <= shift_word_in;
         chunk_tag_ff     <= chunk_tag_in;
         skip_left_ff     <= skip_left_in;
         byte_position_ff <= byte_position_in;
         have_format_ff   <= have_format_in;
         channel_count_ff <= channel_count_in;
         sample_bits_ff   <= sample_bits_in;
         rate_store_ff    <= rate_store_in;
         align_store_ff   <= align_store_in;
         finished_ff      <= finished_in;
      end
   end

   property p_done_is_finished;
      @(posedge clock) disable iff (reset)
         (phase_ff == PH_DONE) == finished_ff;
   endproperty
   a_done_is_finished: assert property (p_done_is_finished)
      else $error("parse phase and finished flag disagree");

   property p_fmt_needs_skip_path;
      @(posedge clock) disable iff (reset)
         (phase_ff == PH_SKIP) |-> (skip_left_ff != '0);
   endproperty
   a_fmt_needs_skip_path: assert property (p_fmt_needs_skip_path)
      else $error("skip phase entered with nothing left to skip");

endmodule

@@ design/wav_riff_header_parser.sv @@
// Top level of the WAV header parser: request register, parser and response register.
//
// Requests carry one byte of a WAV file each: req_tdata is the byte, req_tuser
// marks the first byte of a new file and req_tlast the final byte of the stream.
// The block checks the RIFF and WAVE tags, walks the chunk headers, captures the
// fmt fields and sends one response when the data chunk header is complete, or an
// error response on a bad tag, a missing or short fmt chunk, or truncation.
// Most requests produce no response; bytes after a response are dropped until a
// request with req_tuser set starts a new file.
// A request is registered on acceptance and parsed from the request register
// once the response register is free; a response is then registered for rsp_tvalid.
// One request is taken every cycle unless parsing stalls; the rate is set by the parse
// state update. A response waits in its register while rsp_tready is low;
// parsing then stalls and req_tready drops once the request register is full.
// Reset clears the parse state to the start of a file and empties both registers.
module wav_riff_header_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // first_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata    // status, sample_format, rate_hz,
                                     // frame_bytes, audio_start, audio_length, zero pad
);
   import wrp_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_first_ff;
   logic           in_last_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   wrp_result_type rsp_ff;
   logic           out_free;
   logic           step;
   logic           emit;
   wrp_result_type result;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
      if (step && emit) begin
         rsp_ff <= result;
      end
   end

   wrp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .last_byte  (in_last_ff),
      .emit       (emit),
      .result     (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RSP_BITS){1'b0}}, rsp_ff};

   property p_stalled_request_held;
      @(posedge clock) disable iff (reset)
         (in_valid_ff && !out_free) |=> in_valid_ff;
   endproperty
   a_stalled_request_held: assert property (p_stalled_request_held)
      else $error("request dropped while the response register was full");

   property p_response_from_step;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid_ff) |-> $past(step);
   endproperty
   a_response_from_step: assert property (p_response_from_step)
      else $error("response appeared without a parsed request");

   property p_error_fields_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && rsp_ff.status != ST_OK) |->
            (rsp_ff.audio_length == '0 && rsp_ff.audio_start == '0
             && rsp_ff.rate_hz == '0 && rsp_ff.frame_bytes == '0);
   endproperty
   a_error_fields_zero: assert property (p_error_fields_zero)
      else $error("error response carries nonzero fields");

endmodule
